/* hw/rtl/ceq_pkg.sv */
// ----------------------------------------------------------------------------
// ceq_pkg
// Shared types, codes and pointer helpers for the coalescing event queue.
// ----------------------------------------------------------------------------
package ceq_pkg;

    localparam int DEPTH = 32;
    localparam int PTR_W = $clog2(DEPTH);

    typedef logic [PTR_W-1:0] t_ptr;
    typedef logic [PTR_W:0]   t_wptr;

    // operation codes
    localparam logic [1:0] KIND_FOLD    = 2'd0;
    localparam logic [1:0] KIND_ENQUEUE = 2'd1;
    localparam logic [1:0] KIND_DEQUEUE = 2'd2;
    localparam logic [1:0] KIND_PURGE   = 2'd3;

    // result status codes
    localparam logic [2:0] ST_APPENDED  = 3'd0;
    localparam logic [2:0] ST_MERGED    = 3'd1;
    localparam logic [2:0] ST_DROPPED   = 3'd2;
    localparam logic [2:0] ST_DELIVERED = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;
    localparam logic [2:0] ST_PURGED    = 3'd5;
    localparam logic [2:0] ST_IGNORED   = 3'd6;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  event_type;
        logic [31:0] event_data;
        logic [15:0] element_id;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  out_type;
        logic [31:0] out_data;
        logic [15:0] out_element;
        logic [4:0]  removed_count;
        logic [4:0]  fill_level;
    } t_rsp;

    typedef struct packed {
        logic [7:0]  event_type;
        logic [31:0] event_data;
        logic [15:0] element_id;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // circular increment
    function automatic t_ptr ptr_inc(input t_ptr p);
        if (p == t_ptr'(DEPTH - 1)) begin
            return '0;
        end
        return p + t_ptr'(1);
    endfunction

    // fit a pointer-sized count into the 5-bit result fields
    function automatic logic [4:0] cnt5(input t_ptr c);
        logic [31:0] v;
        v = 32'(c);
        return v[4:0];
    endfunction

    // entries held between head and tail
    function automatic logic [4:0] fill_of(input t_ptr h, input t_ptr t);
        t_wptr d;
        if (t >= h) begin
            d = {1'b0, t} - {1'b0, h};
        end else begin
            d = {1'b0, t} + t_wptr'(DEPTH) - {1'b0, h};
        end
        return cnt5(d[PTR_W-1:0]);
    endfunction

endpackage

/* hw/rtl/coalescing_event_queue.sv */
// ----------------------------------------------------------------------------
// coalescing_event_queue
// Circular event queue with fold (coalesce), enqueue, dequeue and purge.
// ----------------------------------------------------------------------------
// timing: enqueue, ignored fold and empty dequeue answer in the cycle after
// start; dequeue answers from S_DEQ once the head slot is read; fold scans in
// S_FOLD up to the match (all held entries when none matches); purge scans all held entries in S_PURGE.
// the slot RAM's single read port sets the scan rate at one entry per cycle.
// busy is low again in the cycle the done strobe is shown; a new request may
// start then. sync active-low reset empties the queue; slot contents persist.
module coalescing_event_queue
    import ceq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_DEQ   = 2'd1;
    localparam logic [1:0] S_FOLD  = 2'd2;
    localparam logic [1:0] S_PURGE = 2'd3;

    logic [1:0] r_state, n_state;
    t_ptr       r_head, n_head;
    t_ptr       r_tail, n_tail;
    t_ptr       r_issue, n_issue;
    t_ptr       r_cmp_ptr, n_cmp_ptr;
    t_ptr       r_wr_ptr, n_wr_ptr;
    t_ptr       r_removed, n_removed;
    logic       r_cmp_v, n_cmp_v;
    logic       r_done, n_done;
    t_req       r_req, n_req;
    t_rsp       r_rsp, n_rsp;
    t_rsp       v_rsp;

    logic       mem_we;
    t_ptr       mem_waddr;
    t_entry     mem_wdata;
    logic       mem_re;
    t_ptr       mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata_raw;
    t_entry     mem_rdata;

    logic       full;
    logic       fold_match;
    logic       purge_keep;
    logic       purge_drop;
    t_ptr       wr_ptr_nx;
    t_ptr       removed_nx;

    // slot storage
    ceq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata_raw)
    );

    assign mem_rdata = t_entry'(mem_rdata_raw);

    // compare stage on the entry read last cycle
    assign full       = (ptr_inc(r_tail) == r_head);
    assign fold_match = r_cmp_v && (mem_rdata.event_type == r_req.event_type)
                        && (mem_rdata.element_id == r_req.element_id);
    assign purge_drop = r_cmp_v && (mem_rdata.element_id == r_req.element_id);
    assign purge_keep = r_cmp_v && (mem_rdata.element_id != r_req.element_id);
    assign wr_ptr_nx  = purge_keep ? ptr_inc(r_wr_ptr) : r_wr_ptr;
    assign removed_nx = r_removed + t_ptr'(purge_drop);

    // request sequencer
    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_issue   = r_issue;
        n_cmp_ptr = r_cmp_ptr;
        n_wr_ptr  = r_wr_ptr;
        n_removed = r_removed;
        n_cmp_v   = r_cmp_v;
        n_req     = r_req;
        n_rsp     = r_rsp;
        n_done    = 1'b0;
        v_rsp     = '0;
        mem_we    = 1'b0;
        mem_waddr = r_tail;
        mem_wdata = '{event_type: r_req.event_type, event_data: r_req.event_data,
                      element_id: r_req.element_id};
        mem_re    = 1'b0;
        mem_raddr = r_issue;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req = i_req;
                    case (i_req.kind)
                        KIND_FOLD: begin
                            if (i_req.element_id == 16'd0) begin
                                n_done       = 1'b1;
                                v_rsp.status = ST_IGNORED;
                            end else begin
                                n_state = S_FOLD;
                                n_issue = r_head;
                                n_cmp_v = 1'b0;
                            end
                        end
                        KIND_ENQUEUE: begin
                            n_done = 1'b1;
                            if (i_req.element_id == 16'd0 || full) begin
                                v_rsp.status = ST_DROPPED;
                            end else begin
                                mem_we       = 1'b1;
                                mem_waddr    = r_tail;
                                mem_wdata    = '{event_type: i_req.event_type,
                                                 event_data: i_req.event_data,
                                                 element_id: i_req.element_id};
                                n_tail       = ptr_inc(r_tail);
                                v_rsp.status = ST_APPENDED;
                            end
                        end
                        KIND_DEQUEUE: begin
                            if (r_head == r_tail) begin
                                n_done       = 1'b1;
                                v_rsp.status = ST_EMPTY;
                            end else begin
                                mem_re    = 1'b1;
                                mem_raddr = r_head;
                                n_state   = S_DEQ;
                            end
                        end
                        KIND_PURGE: begin
                            n_state   = S_PURGE;
                            n_issue   = r_head;
                            n_wr_ptr  = r_head;
                            n_removed = '0;
                            n_cmp_v   = 1'b0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // head entry arrives from the RAM
            S_DEQ: begin
                n_done            = 1'b1;
                v_rsp.status      = ST_DELIVERED;
                v_rsp.out_type    = mem_rdata.event_type;
                v_rsp.out_data    = mem_rdata.event_data;
                v_rsp.out_element = mem_rdata.element_id;
                n_head            = ptr_inc(r_head);
                n_state           = S_IDLE;
            end

            // scan head to tail, overwrite payload on the first match, else append at tail (drop when full)
            S_FOLD: begin
                if (fold_match) begin
                    mem_we       = 1'b1;
                    mem_waddr    = r_cmp_ptr;
                    mem_wdata    = '{event_type: mem_rdata.event_type,
                                     event_data: r_req.event_data,
                                     element_id: mem_rdata.element_id};
                    n_done       = 1'b1;
                    v_rsp.status = ST_MERGED;
                    n_cmp_v      = 1'b0;
                    n_state      = S_IDLE;
                end else if (r_issue == r_tail) begin
                    n_done  = 1'b1;
                    n_cmp_v = 1'b0;
                    n_state = S_IDLE;
                    if (full) begin
                        v_rsp.status = ST_DROPPED;
                    end else begin
                        mem_we       = 1'b1;
                        mem_waddr    = r_tail;
                        n_tail       = ptr_inc(r_tail);
                        v_rsp.status = ST_APPENDED;
                    end
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_issue;
                    n_cmp_v   = 1'b1;
                    n_cmp_ptr = r_issue;
                    n_issue   = ptr_inc(r_issue);
                end
            end

            // compact survivors toward head, write pointer trails the read
            S_PURGE: begin
                if (purge_keep) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wr_ptr;
                    mem_wdata = mem_rdata;
                end
                n_wr_ptr  = wr_ptr_nx;
                n_removed = removed_nx;
                if (r_issue == r_tail) begin
                    n_done              = 1'b1;
                    v_rsp.status        = ST_PURGED;
                    v_rsp.removed_count = cnt5(removed_nx);
                    n_tail              = wr_ptr_nx;
                    n_cmp_v             = 1'b0;
                    n_state             = S_IDLE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_issue;
                    n_cmp_v   = 1'b1;
                    n_cmp_ptr = r_issue;
                    n_issue   = ptr_inc(r_issue);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // result register load
        if (n_done) begin
            n_rsp            = v_rsp;
            n_rsp.fill_level = fill_of(n_head, n_tail);
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_cmp_v <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cmp_v <= n_cmp_v;
            r_done  <= n_done;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_issue   <= n_issue;
        r_cmp_ptr <= n_cmp_ptr;
        r_wr_ptr  <= n_wr_ptr;
        r_removed <= n_removed;
        r_req     <= n_req;
        r_rsp     <= n_rsp;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule

/* hw/rtl/ceq_ram.sv */
// ----------------------------------------------------------------------------
// ceq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ceq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered data held while i_re is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* tb/coalescing_event_queue_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalescing_event_queue_tb
// Drives fold, enqueue, dequeue and purge requests through the start/busy
// handshake with random gaps. A shadow copy of the circular queue predicts
// each response, and every done strobe is checked field by field in order.
// ----------------------------------------------------------------------------
module coalescing_event_queue_tb;
    import ceq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int N_RANDOM       = 360;

    typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED} t_seg;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_done;
    t_rsp o_rsp;

    // requests waiting to be driven, responses waiting to be seen
    t_req req_backlog [$];
    t_rsp rsp_expected [$];

    // shadow copy of the queue contents and pointers
    logic [7:0]  q_type [DEPTH];
    logic [31:0] q_data [DEPTH];
    logic [15:0] q_elem [DEPTH];
    t_ptr        q_head = '0;
    t_ptr        q_tail = '0;

    int mismatches  = 0;
    int quiet_run   = 0;
    int gap_left    = 0;
    int idle_cycles = 0;

    coalescing_event_queue dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_ptr wrap_inc(input t_ptr p);
        return (int'(p) == DEPTH - 1) ? t_ptr'(0) : t_ptr'(p + 1'b1);
    endfunction

    // append at tail unless the element is 0 or the queue is full
    function automatic logic [2:0] push_entry(input t_req rq);
        if (rq.element_id == '0 || wrap_inc(q_tail) == q_head) begin
            return ST_DROPPED;
        end
        q_type[q_tail] = rq.event_type;
        q_data[q_tail] = rq.event_data;
        q_elem[q_tail] = rq.element_id;
        q_tail = wrap_inc(q_tail);
        return ST_APPENDED;
    endfunction

    // apply one request to the shadow queue and build the response it causes
    function automatic t_rsp apply_event_op(input t_req rq);
        t_rsp       r;
        t_ptr       p;
        t_ptr       w;
        logic       hit;
        logic [4:0] n_removed;
        r = '0;
        r.status = ST_IGNORED;
        hit = 1'b0;
        n_removed = '0;
        case (rq.kind)
            KIND_FOLD: begin
                if (rq.element_id != '0) begin
                    p = q_head;
                    while (p != q_tail && !hit) begin
                        if (q_type[p] == rq.event_type && q_elem[p] == rq.element_id) begin
                            q_data[p] = rq.event_data;
                            hit = 1'b1;
                        end else begin
                            p = wrap_inc(p);
                        end
                    end
                    r.status = hit ? ST_MERGED : push_entry(rq);
                end
            end
            KIND_ENQUEUE: begin
                r.status = push_entry(rq);
            end
            KIND_DEQUEUE: begin
                if (q_head != q_tail) begin
                    r.out_type    = q_type[q_head];
                    r.out_data    = q_data[q_head];
                    r.out_element = q_elem[q_head];
                    q_head = wrap_inc(q_head);
                    r.status = ST_DELIVERED;
                end else begin
                    r.status = ST_EMPTY;
                end
            end
            default: begin
                // compact survivors toward head, keeping their order
                w = q_head;
                p = q_head;
                while (p != q_tail) begin
                    if (q_elem[p] == rq.element_id) begin
                        n_removed = n_removed + 1'b1;
                    end else begin
                        q_type[w] = q_type[p];
                        q_data[w] = q_data[p];
                        q_elem[w] = q_elem[p];
                        w = wrap_inc(w);
                    end
                    p = wrap_inc(p);
                end
                q_tail = w;
                r.status = ST_PURGED;
                r.removed_count = n_removed;
            end
        endcase
        r.fill_level = 5'((int'(q_tail) + DEPTH - int'(q_head)) % DEPTH);
        return r;
    endfunction

    function automatic t_req mk_req(input logic [1:0] kind, input logic [7:0] etype,
                                    input logic [31:0] data, input logic [15:0] elem);
        t_req rq;
        rq.kind       = kind;
        rq.event_type = etype;
        rq.event_data = data;
        rq.element_id = elem;
        return rq;
    endfunction

    // random request; the segment kind biases toward filling or draining
    function automatic t_req rand_req(input t_seg seg);
        int r;
        int fold_lim;
        int enq_lim;
        int deq_lim;
        logic [1:0]  kind;
        logic [7:0]  etype;
        logic [15:0] elem;
        case (seg)
            SEG_FILL: begin
                fold_lim = 45; enq_lim = 90; deq_lim = 96;
            end
            SEG_DRAIN: begin
                fold_lim = 10; enq_lim = 20; deq_lim = 90;
            end
            default: begin
                fold_lim = 30; enq_lim = 60; deq_lim = 90;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < fold_lim) begin
            kind = KIND_FOLD;
        end else if (r < enq_lim) begin
            kind = KIND_ENQUEUE;
        end else if (r < deq_lim) begin
            kind = KIND_DEQUEUE;
        end else begin
            kind = KIND_PURGE;
        end
        // small type and element pools so folds and purges find matches
        etype = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 3))
                                             : 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 5) begin
            elem = '0;
        end else if (r < 80) begin
            elem = 16'($urandom_range(1, 4));
        end else begin
            elem = 16'($urandom_range(1, 65535));
        end
        return mk_req(kind, etype, $urandom, elem);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // request driver
    always @(posedge i_clk) begin : drive
        int gap;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left <= 0;
        end else if (start && !busy) begin
            rsp_expected.push_back(apply_event_op(i_req));
            if (quiet_run > 0) begin
                gap = 0;
                quiet_run <= quiet_run - 1;
            end else begin
                gap = pick_gap();
                if ($urandom_range(0, 49) == 0) begin
                    quiet_run <= $urandom_range(20, 60);
                end
            end
            if (gap == 0 && req_backlog.size() > 0) begin
                i_req <= req_backlog.pop_front();
            end else begin
                start <= 1'b0;
                gap_left <= gap;
            end
        end else if (!start) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (req_backlog.size() > 0) begin
                i_req <= req_backlog.pop_front();
                start <= 1'b1;
            end
        end
    end

    task automatic cmp_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // response monitor
    always @(posedge i_clk) begin : watch_rsp
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (rsp_expected.size() == 0) begin
                $display("%0t: unexpected response, expected none, got %h", $time, o_rsp);
                mismatches++;
            end else begin
                want = rsp_expected.pop_front();
                cmp_field("status", 32'(want.status), 32'(o_rsp.status));
                cmp_field("out_type", 32'(want.out_type), 32'(o_rsp.out_type));
                cmp_field("out_data", want.out_data, o_rsp.out_data);
                cmp_field("out_element", 32'(want.out_element), 32'(o_rsp.out_element));
                cmp_field("removed_count", 32'(want.removed_count),
                          32'(o_rsp.removed_count));
                cmp_field("fill_level", 32'(want.fill_level), 32'(o_rsp.fill_level));
            end
        end
    end

    // watchdog on cycles with neither a request nor a response moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int   n_rand;
        int   seg_len;
        t_seg seg;

        // directed: empty queue corner cases
        req_backlog.push_back(mk_req(KIND_DEQUEUE, 8'h00, 32'h0, 16'h0001));
        req_backlog.push_back(mk_req(KIND_FOLD, 8'h11, 32'hdeadbeef, 16'h0000));
        req_backlog.push_back(mk_req(KIND_ENQUEUE, 8'h22, 32'hcafef00d, 16'h0000));
        req_backlog.push_back(mk_req(KIND_PURGE, 8'h00, 32'h0, 16'h0000));
        // directed: field extremes, merges and appends on type or element miss
        req_backlog.push_back(mk_req(KIND_ENQUEUE, 8'hff, 32'hffffffff, 16'hffff));
        req_backlog.push_back(mk_req(KIND_ENQUEUE, 8'h00, 32'h00000000, 16'h0001));
        req_backlog.push_back(mk_req(KIND_FOLD, 8'h00, 32'h12345678, 16'h0001));
        req_backlog.push_back(mk_req(KIND_FOLD, 8'h01, 32'h55555555, 16'h0001));
        req_backlog.push_back(mk_req(KIND_FOLD, 8'hff, 32'haaaaaaaa, 16'h0001));
        req_backlog.push_back(mk_req(KIND_FOLD, 8'hff, 32'h0badf00d, 16'hffff));
        req_backlog.push_back(mk_req(KIND_ENQUEUE, 8'h00, 32'h00000001, 16'h0001));
        // directed: purges of element 0, a missing element and a present one
        req_backlog.push_back(mk_req(KIND_PURGE, 8'h00, 32'h0, 16'h0000));
        req_backlog.push_back(mk_req(KIND_PURGE, 8'h00, 32'h0, 16'h0007));
        req_backlog.push_back(mk_req(KIND_PURGE, 8'hff, 32'hffffffff, 16'h0001));
        req_backlog.push_back(mk_req(KIND_DEQUEUE, 8'h00, 32'h0, 16'h0000));
        req_backlog.push_back(mk_req(KIND_DEQUEUE, 8'h00, 32'h0, 16'h0000));
        // directed: purge that removes every entry
        req_backlog.push_back(mk_req(KIND_ENQUEUE, 8'h05, 32'h00000005, 16'h8000));
        req_backlog.push_back(mk_req(KIND_FOLD, 8'h06, 32'h00000006, 16'h8000));
        req_backlog.push_back(mk_req(KIND_ENQUEUE, 8'h05, 32'h00000007, 16'h8000));
        req_backlog.push_back(mk_req(KIND_PURGE, 8'h00, 32'h0, 16'h8000));
        req_backlog.push_back(mk_req(KIND_DEQUEUE, 8'h00, 32'h0, 16'h0000));

        // random segments, the first one biased toward filling the queue
        n_rand = 0;
        seg = SEG_FILL;
        while (n_rand < N_RANDOM) begin
            seg_len = $urandom_range(20, 50);
            repeat (seg_len) begin
                req_backlog.push_back(rand_req(seg));
            end
            n_rand += seg_len;
            seg = t_seg'($urandom_range(0, 2));
        end

        // synchronous reset, held low from time zero and then released
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every request to go in and every response to come back
        while (req_backlog.size() != 0 || start || rsp_expected.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/ceq_pkg.sv
hw/rtl/ceq_ram.sv
hw/rtl/coalescing_event_queue.sv
tb/coalescing_event_queue_tb.sv
